// ===== design/sded_pkg.sv =====
// sded_pkg: shared types and constants for the slow descent end detector
// no dependencies; imported by sded_core and slow_descent_end_detector_unit
`default_nettype none

package sded_pkg;

   // field widths fixed by the item format
   localparam int unsigned PRESSURE_W = 23;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned CSR_W      = 16;
   localparam int unsigned CSR_IDX_W  = 4;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_MS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_RATIO  = 4'd1;

   // register reset values
   localparam logic [CSR_W-1:0] INTERVAL_MS_RESET = 16'd2000;
   localparam logic [CSR_W-1:0] SLOW_RATIO_RESET  = 16'd3973;

   // fraction bits of the ratio
   localparam int unsigned RATIO_FRAC_W = 24;

   // one result beat
   typedef struct packed {
      logic                  detected;
      logic                  sample_taken;
      logic [PRESSURE_W-1:0] pressure_rise;
   } result_type;

endpackage : sded_pkg

`default_nettype wire

// ===== design/sded_core.sv =====
// sded_core: sample window, keep decision and rise test for one item a cycle
// depends on sded_pkg
`default_nettype none

module sded_core import sded_pkg::*; #(
   parameter int unsigned WINDOW = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire logic [PRESSURE_W-1:0] pressure,
   input  wire logic [TIME_W-1:0]     time_ms,
   input  wire logic [CSR_W-1:0]      interval_ms,
   input  wire logic [CSR_W-1:0]      slow_ratio,
   output result_type                 res
);

   localparam int unsigned FILL_W   = (WINDOW > 2) ? $clog2(WINDOW) : 1;
   localparam int unsigned TAPS     = WINDOW - 1;
   localparam int unsigned PROD_W   = CSR_W + PRESSURE_W;
   localparam int unsigned LHS_W    = PRESSURE_W + RATIO_FRAC_W;

   // kept samples, newest in tap 0; the new sample itself completes the window
   logic [PRESSURE_W-1:0] tap_ff [TAPS];

   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic                  full_ff, full_in;
   logic                  end_found_ff, end_found_in;
   logic [TIME_W-1:0]     last_kept_ff, last_kept_in;

   logic [TIME_W-1:0]     elapsed;
   logic                  keep;
   logic                  full_now;
   logic [PRESSURE_W-1:0] oldest;
   logic [PRESSURE_W:0]   diff;
   logic                  no_fall;
   logic [LHS_W-1:0]      lhs;
   logic [PROD_W-1:0]     rhs;
   logic                  hit;

   // keep decision on wrapping elapsed time
   always_comb begin
      elapsed  = time_ms - last_kept_ff;
      keep     = !end_found_ff && (elapsed >= {{(TIME_W-CSR_W){1'b0}}, interval_ms});
      full_now = full_ff || (fill_ff == FILL_W'(WINDOW - 1));
   end

   // rise against the oldest sample still in the window
   always_comb begin
      oldest  = tap_ff[TAPS-1];
      diff    = {1'b0, pressure} - {1'b0, oldest};
      no_fall = !diff[PRESSURE_W];
      lhs     = {diff[PRESSURE_W-1:0], {RATIO_FRAC_W{1'b0}}};
      rhs     = slow_ratio * oldest;
      hit     = keep && full_now && no_fall && (lhs < {{(LHS_W-PROD_W){1'b0}}, rhs});
   end

   // result of this item
   always_comb begin
      res.detected      = end_found_ff || hit;
      res.sample_taken  = keep;
      res.pressure_rise = hit ? diff[PRESSURE_W-1:0] : '0;
   end

   // next control state
   always_comb begin
      fill_in      = fill_ff;
      full_in      = full_ff;
      end_found_in = end_found_ff;
      last_kept_in = last_kept_ff;
      if (fire && keep) begin
         last_kept_in = time_ms;
         if (!full_ff) begin
            if (fill_ff == FILL_W'(WINDOW - 1)) begin
               full_in = 1'b1;
            end else begin
               fill_in = fill_ff + 1'b1;
            end
         end
         if (hit) begin
            end_found_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         full_ff      <= 1'b0;
         end_found_ff <= 1'b0;
         last_kept_ff <= '0;
      end else begin
         fill_ff      <= fill_in;
         full_ff      <= full_in;
         end_found_ff <= end_found_in;
         last_kept_ff <= last_kept_in;
      end
   end

   // sample shift line, moves only on a kept sample
   always_ff @(posedge clock) begin
      if (fire && keep) begin
         tap_ff[0] <= pressure;
         for (int i = 1; i < TAPS; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   // a reported rise only comes with detection
   assert property (@(posedge clock) disable iff (reset)
      (res.pressure_rise != '0) |-> res.detected)
      else $error("rise reported without detection");

   // nothing is kept once the end has been found
   assert property (@(posedge clock) disable iff (reset)
      end_found_ff |-> (!res.sample_taken && res.detected))
      else $error("sample kept after detection");

   // detection needs a full window
   assert property (@(posedge clock) disable iff (reset)
      (fire && !end_found_ff && res.detected) |=> full_ff && end_found_ff)
      else $error("detection without a full window");

endmodule : sded_core

`default_nettype wire

// ===== design/slow_descent_end_detector_unit.sv =====
// slow_descent_end_detector_unit: top level with handshakes and registers
// depends on sded_pkg and sded_core
// path: a request beat goes through the input register, then the response register
// throughput: one item per cycle unless rsp_ready stalls; each register holds one
// beat, so a request is taken while a response waits only if the input is empty
// reset: synchronous, clears the window fill, detection flag and last kept time,
// and loads interval_ms = 2000 and slow_ratio = 3973; window contents are not cleared
`default_nettype none

module slow_descent_end_detector_unit import sded_pkg::*; #(
   parameter int unsigned WINDOW = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [PRESSURE_W-1:0] req_pressure,
   input  wire logic [TIME_W-1:0]     req_time_ms,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_detected,
   output logic                       rsp_sample_taken,
   output logic [PRESSURE_W-1:0]      rsp_pressure_rise,
   // register write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]      csr_wdata
);

   logic                  in_valid_ff;
   logic [PRESSURE_W-1:0] in_pressure_ff;
   logic [TIME_W-1:0]     in_time_ff;
   logic                  rsp_valid_ff;
   result_type            rsp_ff;
   logic [CSR_W-1:0]      interval_ff;
   logic [CSR_W-1:0]      ratio_ff;

   logic                  advance;
   logic                  req_beat;
   result_type            res;

   // handshake control
   always_comb begin
      advance   = !rsp_valid_ff || rsp_ready;
      req_ready = !in_valid_ff || advance;
      req_beat  = req_valid && req_ready;
      csr_ready = 1'b1;
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_MS_RESET;
         ratio_ff    <= SLOW_RATIO_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_INTERVAL_MS: interval_ff <= csr_wdata;
            CSR_SLOW_RATIO:  ratio_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_pressure_ff <= req_pressure;
         in_time_ff     <= req_time_ms;
      end
   end

   sded_core #(
      .WINDOW (WINDOW)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (in_valid_ff && advance),
      .pressure    (in_pressure_ff),
      .time_ms     (in_time_ff),
      .interval_ms (interval_ff),
      .slow_ratio  (ratio_ff),
      .res         (res)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         rsp_ff <= res;
      end
   end

   always_comb begin
      rsp_valid         = rsp_valid_ff;
      rsp_detected      = rsp_ff.detected;
      rsp_sample_taken  = rsp_ff.sample_taken;
      rsp_pressure_rise = rsp_ff.pressure_rise;
   end

endmodule : slow_descent_end_detector_unit

`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for slow_descent_end_detector_unit
// depends on sded_pkg and the unit; predicts each response beat from its own window model
`timescale 1ns / 100ps

module tb_top;
   import sded_pkg::*;

   localparam int unsigned WINDOW      = 10;
   localparam int          P_TOP       = 2**PRESSURE_W - 1;
   localparam int unsigned SETTLE      = 5;
   localparam int unsigned CYCLE_LIMIT = 600000;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_ready;
   logic [PRESSURE_W-1:0] req_pressure = '0;
   logic [TIME_W-1:0]     req_time_ms  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready    = 1'b0;
   logic                  rsp_detected;
   logic                  rsp_sample_taken;
   logic [PRESSURE_W-1:0] rsp_pressure_rise;
   logic                  csr_valid    = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_W-1:0]      csr_wdata    = '0;

   // own copy of the registers and window state
   logic [CSR_W-1:0]      interval_reg = INTERVAL_MS_RESET;
   logic [CSR_W-1:0]      ratio_reg    = SLOW_RATIO_RESET;
   logic [PRESSURE_W-1:0] ring_mem [WINDOW];
   int unsigned           ring_pos     = 0;
   bit                    ring_full    = 1'b0;
   bit                    end_seen     = 1'b0;
   logic [TIME_W-1:0]     last_kept    = '0;

   result_type            expected_results [$];
   int unsigned           errors       = 0;
   int unsigned           cycle_count  = 0;
   bit                    no_idle      = 1'b0;
   bit                    ready_on     = 1'b0;
   int unsigned           run_left     = 0;
   logic [TIME_W-1:0]     stamp        = '0;
   logic [PRESSURE_W-1:0] drift_level  = 23'd6500000;

   slow_descent_end_detector_unit #(.WINDOW(WINDOW)) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pressure      (req_pressure),
      .req_time_ms       (req_time_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_detected      (rsp_detected),
      .rsp_sample_taken  (rsp_sample_taken),
      .rsp_pressure_rise (rsp_pressure_rise),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < WINDOW; i++) ring_mem[i] = '0;
   end

   // window model helpers
   function automatic bit will_compare();
      return ring_full || ((ring_pos + 1) % WINDOW == 0);
   endfunction

   function automatic logic [PRESSURE_W-1:0] compared_oldest();
      return ring_mem[(ring_pos + 1) % WINDOW];
   endfunction

   // smallest rise that does not count as a slow descent against this oldest sample
   function automatic int unsigned min_rise(input logic [PRESSURE_W-1:0] oldest);
      logic [63:0] prod;
      prod = 64'(ratio_reg) * 64'(oldest) + 64'h00FF_FFFF;
      return 32'(prod >> RATIO_FRAC_W);
   endfunction

   // one sample through the detector; state is only updated when commit is set
   function automatic result_type descent_step(input logic [PRESSURE_W-1:0] p,
                                               input logic [TIME_W-1:0] t, input bit commit);
      result_type        r;
      logic [TIME_W-1:0] elapsed;
      logic [PRESSURE_W-1:0] oldest;
      logic [PRESSURE_W-1:0] rise;
      logic [63:0]       lhs;
      logic [63:0]       rhs;
      r = '0;
      if (end_seen) begin
         r.detected = 1'b1;
         return r;
      end
      elapsed = t - last_kept;
      if (elapsed < 32'(interval_reg)) return r;
      r.sample_taken = 1'b1;
      if (will_compare()) begin
         oldest = compared_oldest();
         if (p >= oldest) begin
            rise = p - oldest;
            lhs  = 64'(rise) << RATIO_FRAC_W;
            rhs  = 64'(ratio_reg) * 64'(oldest);
            if (lhs < rhs) begin
               r.detected      = 1'b1;
               r.pressure_rise = rise;
            end
         end
      end
      if (commit) begin
         last_kept          = t;
         ring_full          = will_compare();
         ring_mem[ring_pos] = p;
         ring_pos           = (ring_pos + 1) % WINDOW;
         if (r.detected) end_seen = 1'b1;
      end
      return r;
   endfunction

   // moves a pressure out of detection range so the run keeps going
   function automatic logic [PRESSURE_W-1:0] keep_running(input logic [PRESSURE_W-1:0] p,
                                                          input logic [TIME_W-1:0] t);
      result_type            trial;
      logic [PRESSURE_W-1:0] oldest;
      int unsigned           m;
      trial = descent_step(p, t, 1'b0);
      if (!trial.detected || end_seen) return p;
      oldest = compared_oldest();
      m      = min_rise(oldest);
      if (int'(oldest) + int'(m) <= P_TOP) return oldest + PRESSURE_W'(m);
      return PRESSURE_W'($urandom_range(0, oldest - 1));
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // lower valid and wait until every expected beat has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_INTERVAL_MS) interval_reg = data;
      else if (idx == CSR_SLOW_RATIO) ratio_reg = data;
   endtask

   // one request beat; prediction is made at the edge it is taken
   task automatic send_sample(input logic [PRESSURE_W-1:0] p, input logic [TIME_W-1:0] t);
      int unsigned gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pressure <= p;
      req_time_ms  <= t;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(descent_step(p, t, 1'b1));
   endtask

   task automatic send_random_sample();
      int unsigned           r;
      int                    level;
      logic [TIME_W-1:0]     delta;
      logic [PRESSURE_W-1:0] oldest;
      logic [PRESSURE_W-1:0] p;
      // timestamp step: mostly on time, some early, some anywhere in the 32-bit range
      r = $urandom_range(0, 99);
      if (r < 65) delta = 32'(interval_reg) + $urandom_range(0, 40);
      else if (r < 85 && interval_reg != 0) delta = $urandom_range(0, interval_reg - 1);
      else delta = $urandom;
      stamp = stamp + delta;
      // pressure: slow drift, right at the threshold, or noise
      r = $urandom_range(0, 99);
      if (r < 45) begin
         level = int'(drift_level);
         level = level + int'($urandom_range(0, 200)) - int'($urandom_range(0, 300));
         if (level < 0) level = 0;
         if (level > P_TOP) level = P_TOP;
         drift_level = PRESSURE_W'(level);
         p = drift_level;
      end else if (r < 75 && will_compare()) begin
         oldest = compared_oldest();
         level  = int'(oldest) + int'(min_rise(oldest)) + int'($urandom_range(0, 2));
         if (level > P_TOP) level = P_TOP;
         p = PRESSURE_W'(level);
      end else begin
         p = PRESSURE_W'($urandom);
      end
      send_sample(keep_running(p, stamp), stamp);
   endtask

   task automatic random_registers();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 20) csr_write(CSR_INTERVAL_MS, 16'd0);
      else if (r < 60) csr_write(CSR_INTERVAL_MS, CSR_W'($urandom_range(1, 60)));
      else if (r < 85) csr_write(CSR_INTERVAL_MS, CSR_W'($urandom_range(61, 5000)));
      else if (r < 93) csr_write(CSR_INTERVAL_MS, 16'hFFFF);
      else csr_write(CSR_INTERVAL_MS, CSR_W'($urandom));
      r = $urandom_range(0, 99);
      if (r < 25) csr_write(CSR_SLOW_RATIO, 16'd0);
      else if (r < 45) csr_write(CSR_SLOW_RATIO, 16'hFFFF);
      else if (r < 55) csr_write(CSR_SLOW_RATIO, 16'd1);
      else csr_write(CSR_SLOW_RATIO, CSR_W'($urandom));
      if ($urandom_range(0, 3) == 0)
         csr_write(CSR_IDX_W'($urandom_range(2, 15)), CSR_W'($urandom));
   endtask

   // reset values: early samples, ring fill, falling pressure, timestamp wrap
   task automatic test_reset_defaults();
      send_sample(PRESSURE_W'(P_TOP), 32'd0);
      send_sample(23'h2AAAAA, 32'd1999);
      for (int i = 0; i < WINDOW - 1; i++)
         send_sample(PRESSURE_W'(P_TOP - i * 900000), 32'(2000 + i * 2000));
      send_sample('0, 32'hFFFF_FFFF);
      send_sample(23'h555555, 32'h0000_0100);
      stamp = 32'hFFFF_FFFF;
   endtask

   // register extremes, ignored index, equal pressure and the exact threshold
   task automatic test_register_limits();
      csr_write(CSR_INTERVAL_MS, 16'd0);
      csr_write(CSR_SLOW_RATIO, 16'd0);
      csr_write(4'hF, 16'hFFFF);
      csr_write(CSR_IDX_W'($urandom_range(2, 14)), CSR_W'($urandom));
      stamp = stamp + 5;
      // 409600 is 4096 * 100, so ratio 4096 puts a rise of 100 exactly on the threshold
      repeat (WINDOW) send_sample(23'd409600, stamp);
      csr_write(CSR_SLOW_RATIO, 16'h1000);
      csr_write(CSR_INTERVAL_MS, 16'hFFFF);
      send_sample(23'd409700, stamp + 32'd65534);
      stamp = stamp + 32'd65535;
      send_sample(23'd409700, stamp);
      stamp = stamp + 32'd65535;
      send_sample(23'd409599, stamp);
   endtask

   task automatic test_random_stream();
      for (int phase = 0; phase < 10; phase++) begin
         random_registers();
         no_idle = (phase == 4);
         for (int k = 0; k < 85; k++) begin
            if (phase == 2 && k == 40) wait_for_results();
            send_random_sample();
         end
         no_idle = 1'b0;
      end
   endtask

   // fill with high pressure, trigger just under the threshold, then sticky flag
   task automatic test_end_detection();
      logic [PRESSURE_W-1:0] oldest;
      csr_write(CSR_SLOW_RATIO, 16'd0);
      csr_write(CSR_INTERVAL_MS, 16'd100);
      repeat (WINDOW) begin
         stamp = stamp + 100;
         send_sample(PRESSURE_W'(8000000 + $urandom_range(0, 1000)), stamp);
      end
      csr_write(CSR_SLOW_RATIO, 16'hFFFF);
      oldest = compared_oldest();
      stamp  = stamp + 100;
      send_sample(oldest + PRESSURE_W'(min_rise(oldest) - 1), stamp);
      repeat (12) begin
         stamp = stamp + $urandom;
         send_sample(PRESSURE_W'($urandom), stamp);
      end
      csr_write(CSR_INTERVAL_MS, 16'd0);
      repeat (4) send_sample(PRESSURE_W'($urandom), stamp);
   endtask

   // response stalls
   always @(posedge clock) begin
      if (run_left != 0) begin
         run_left--;
      end else if (no_idle || !ready_on) begin
         ready_on = 1'b1;
         run_left = $urandom_range(0, 15);
      end else begin
         run_left = pick_gap();
         ready_on = (run_left == 0);
      end
      rsp_ready <= ready_on;
   end

   task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
      if (act !== exp) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
         errors++;
      end
   endtask

   // compare every response beat with the oldest prediction
   always @(posedge clock) begin
      result_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, actual %0h %0h %0h",
                     $time, rsp_detected, rsp_sample_taken, rsp_pressure_rise);
            errors++;
         end else begin
            exp = expected_results.pop_front();
            check_field("detected", 32'(exp.detected), 32'(rsp_detected));
            check_field("sample_taken", 32'(exp.sample_taken), 32'(rsp_sample_taken));
            check_field("pressure_rise", 32'(exp.pressure_rise), 32'(rsp_pressure_rise));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_register_limits();
      test_random_stream();
      test_end_detection();
      wait_for_results();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
